### sv/jdtrd_pkg.sv
`default_nettype none

package jdtrd_pkg;

   // Width of the per-direction poll counters.
   localparam int COUNT_BITS = 8;
   localparam int DATA_W     = 8;
   localparam int OFFSET_W   = 3;
   // Compare width that holds both a counter and an 8-bit limit.
   localparam int CMP_W      = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_TAP_GAP   = 2'd0;
   localparam logic [1:0] REG_PRESS_LEN = 2'd1;
   localparam logic [1:0] REG_LOCKOUT   = 2'd2;

   localparam logic [DATA_W-1:0] TAP_GAP_RESET   = 8'd10;
   localparam logic [DATA_W-1:0] PRESS_LEN_RESET = 8'd5;
   localparam logic [DATA_W-1:0] LOCKOUT_RESET   = 8'd100;

   localparam logic [DATA_W-1:0] SIGNATURE   = 8'h6a;
   localparam logic [DATA_W-1:0] BUTTON_MASK = 8'h30;
   localparam logic [DATA_W-1:0] P1_MASK     = 8'hcf;
   localparam logic [DATA_W-1:0] P2_MASK     = 8'h0f;

   localparam logic [OFFSET_W-1:0] AUX_OFFSET = 3'd4;
   localparam logic [OFFSET_W-1:0] SNAP_COUNT = 3'd4;

   typedef logic [COUNT_BITS-1:0] count_type;
   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_READ    = 1'b1
   } op_type;

   typedef enum logic {
      RD_SNAPSHOT = 1'b0,
      RD_AUX      = 1'b1
   } rd_sel_type;

   // One classified beat on its way from the front to the back part.
   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   cmd;
      logic [DATA_W-1:0]   p1;
      logic [DATA_W-1:0]   p2;
      rd_sel_type          sel;
      logic [1:0]          snap_idx;
      logic [DATA_W-1:0]   aux;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] tap_gap;
      logic [DATA_W-1:0] press_len;
      logic [DATA_W-1:0] lockout;
   } cfg_type;

endpackage

`default_nettype wire

### sv/jdtrd_csr.sv
`default_nettype none

module jdtrd_csr
   import jdtrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   logic [DATA_W-1:0] tap_gap_ff, press_len_ff, lockout_ff;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes land on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_gap_ff   <= TAP_GAP_RESET;
         press_len_ff <= PRESS_LEN_RESET;
         lockout_ff   <= LOCKOUT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TAP_GAP:   tap_gap_ff   <= csr_pwdata[DATA_W-1:0];
            REG_PRESS_LEN: press_len_ff <= csr_pwdata[DATA_W-1:0];
            REG_LOCKOUT:   lockout_ff   <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux; unmapped addresses read as zero.
   always_comb begin
      case (reg_idx)
         REG_TAP_GAP:   csr_prdata = CSR_DATA_W'(tap_gap_ff);
         REG_PRESS_LEN: csr_prdata = CSR_DATA_W'(press_len_ff);
         REG_LOCKOUT:   csr_prdata = CSR_DATA_W'(lockout_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.tap_gap   = tap_gap_ff;
   assign cfg.press_len = press_len_ff;
   assign cfg.lockout   = lockout_ff;

endmodule

`default_nettype wire

### sv/jdtrd_front.sv
`default_nettype none

module jdtrd_front
   import jdtrd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output      logic                req_full,
   input  wire logic                req_opcode,
   input  wire logic [DATA_W-1:0]   req_command_data,
   input  wire logic [DATA_W-1:0]   req_player_one_port,
   input  wire logic [DATA_W-1:0]   req_player_two_port,
   input  wire logic [OFFSET_W-1:0] req_reg_offset,
   input  wire logic [DATA_W-1:0]   req_aux_port,
   output      logic                q_push,
   output      item_type            q_item,
   input  wire logic                q_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // The holding stage frees up whenever its beat moves into the queue.
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_item   = item_ff;

   // Classify the beat: resolve the read offset to a snapshot index or the
   // auxiliary port, with offsets above the auxiliary one reading snapshot 0.
   always_comb begin
      item_in.op       = op_type'(req_opcode);
      item_in.cmd      = req_command_data;
      item_in.p1       = req_player_one_port;
      item_in.p2       = req_player_two_port;
      item_in.aux      = req_aux_port;
      item_in.sel      = (req_reg_offset == AUX_OFFSET) ? RD_AUX : RD_SNAPSHOT;
      item_in.snap_idx = (req_reg_offset < SNAP_COUNT) ? req_reg_offset[1:0] : 2'd0;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### sv/jdtrd_fifo.sv
`default_nettype none

module jdtrd_fifo
   import jdtrd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output      logic     full,
   input  wire logic     pop,
   output      item_type pop_item,
   output      logic     empty
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers wrap naturally at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### sv/jdtrd_back.sv
`default_nettype none

module jdtrd_back
   import jdtrd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire item_type          q_item,
   input  wire logic              q_empty,
   output      logic              q_pop,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      logic [DATA_W-1:0] rsp_read_data
);

   // Direction state, indexed player*2 + direction (0 right, 1 left).
   logic              last_ff [4], last_in [4];
   count_type         rel_ff [4], rel_in [4];
   count_type         prs_ff [4], prs_in [4];
   logic [1:0]        run_ff [2], run_in [2];
   logic              jump_ff [2], jump_in [2];
   logic [DATA_W-1:0] snap_ff [4], snap_in [4];
   logic [DATA_W-1:0] cmd_ff;

   // Two-beat result buffer.
   logic [DATA_W-1:0] out_buf_ff [2];
   logic              out_wr_ff, out_rd_ff;
   logic [1:0]        out_cnt_ff;
   logic              out_push, out_pop, out_full;
   logic [DATA_W-1:0] read_val;
   logic              do_cmd;

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   assign out_full = (out_cnt_ff == 2'd2);
   assign q_pop    = !q_empty && ((q_item.op == OP_COMMAND) || !out_full);
   assign do_cmd   = q_pop && (q_item.op == OP_COMMAND);
   assign out_push = q_pop && (q_item.op == OP_READ);
   assign out_pop  = rsp_pop && !rsp_empty;

   assign rsp_empty     = (out_cnt_ff == 2'd0);
   assign rsp_read_data = out_buf_ff[out_rd_ff];

   // Read data: signature while the stored command is zero.
   always_comb begin
      if (cmd_ff == '0) begin
         read_val = SIGNATURE;
      end else if (q_item.sel == RD_AUX) begin
         read_val = q_item.aux;
      end else begin
         read_val = snap_ff[q_item.snap_idx];
      end
   end

   // Poll update for a command beat: release and press counters, run
   // flags, button latch and the rebuilt snapshots.
   always_comb begin
      logic [DATA_W-1:0] ports [2];
      logic [DATA_W-1:0] btn_cur, btn;
      logic [CMP_W-1:0]  lock_w;
      count_type         lock_sat, r, pv;
      logic [1:0]        run_v;
      logic              cur, oth, jl;
      int                k;

      ports[0] = q_item.p1;
      ports[1] = q_item.p2;
      lock_w   = CMP_W'(cfg.lockout);
      if (lock_w > CMP_W'(COUNT_MAX)) begin
         lock_sat = COUNT_MAX;
      end else begin
         lock_sat = COUNT_BITS'(lock_w);
      end

      for (int p = 0; p < 2; p++) begin
         run_v = run_ff[p];
         for (int j = 0; j < 2; j++) begin
            k   = p * 2 + j;
            cur = ports[p][j];
            oth = ports[p][1-j];
            rel_in[k] = rel_ff[k];
            prs_in[k] = prs_ff[k];
            r         = '0;
            pv        = '0;
            if (!cur) begin
               r = last_ff[k] ? '0 : rel_ff[k];
               if (oth) begin
                  r = lock_sat;
               end
               rel_in[k] = sat_inc(r);
               run_v[j]  = 1'b0;
            end else begin
               pv = prs_ff[k];
               if (!last_ff[k]) begin
                  if ((CMP_W'(rel_ff[k]) < CMP_W'(cfg.tap_gap)) &&
                      (CMP_W'(prs_ff[k]) < CMP_W'(cfg.press_len))) begin
                     run_v[j] = 1'b1;
                  end
                  pv = '0;
               end
               prs_in[k] = sat_inc(pv);
            end
            last_in[k] = cur;
         end
         run_in[p] = run_v;

         // Both buttons pass once, then stay masked until all are released.
         btn_cur = ports[p] & BUTTON_MASK;
         btn     = jump_ff[p] ? '0 : btn_cur;
         jl      = jump_ff[p];
         if (btn == BUTTON_MASK) begin
            jl = 1'b1;
         end
         if (btn_cur == '0) begin
            jl = 1'b0;
         end
         jump_in[p]   = jl;
         snap_in[p+2] = DATA_W'(run_v) | btn;
      end

      snap_in[0] = ports[0] & P1_MASK;
      snap_in[1] = ports[1] & P2_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= 1'b0;
            rel_ff[i]  <= '0;
            prs_ff[i]  <= '0;
            snap_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            run_ff[i]  <= '0;
            jump_ff[i] <= 1'b0;
         end
      end else if (do_cmd) begin
         cmd_ff <= q_item.cmd;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= last_in[i];
            rel_ff[i]  <= rel_in[i];
            prs_ff[i]  <= prs_in[i];
            snap_ff[i] <= snap_in[i];
         end
         for (int i = 0; i < 2; i++) begin
            run_ff[i]  <= run_in[i];
            jump_ff[i] <= jump_in[i];
         end
      end
   end

   // Result buffer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (out_push) begin
            out_wr_ff <= !out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= !out_rd_ff;
         end
         if (out_push && !out_pop) begin
            out_cnt_ff <= out_cnt_ff + 2'd1;
         end else if (out_pop && !out_push) begin
            out_cnt_ff <= out_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_buf_ff[out_wr_ff] <= read_val;
      end
   end

endmodule

`default_nettype wire

### sv/joystick_double_tap_run_detector_top.sv
// Joystick double-tap run detector.
// Request channel (req_*): a beat is taken when req_push is high and
// req_full is low. Opcode 0 stores the command byte and polls both joystick
// ports, updating the run flags, button latches and the four snapshots; it
// returns nothing. Opcode 1 reads a snapshot, the auxiliary port, or the
// signature byte while the stored command is zero, and returns one beat.
// Response channel (rsp_*): the oldest result is shown while rsp_empty is
// low and leaves when rsp_pop is high.
// A beat waits in the front holding stage, then passes through a four-entry
// command queue to the back part, which applies it. A read result is
// registered in the result buffer. One beat per cycle is sustained in both
// directions while the receiver keeps popping; the back part's single
// update step per beat sets that figure.
// If the receiver stalls, the two-entry result buffer fills, read beats
// wait in the queue while command beats behind them wait too, and req_full
// rises once the queue and holding stage are full.
// Reset clears all direction state, snapshots and the command, empties all
// queues and restores the registers to 10, 5 and 100.
// Registers on the csr_* port: tap gap limit at 0, press length limit at 4,
// lockout value at 8; they should be written while the block is idle.
`default_nettype none

module joystick_double_tap_run_detector_top
   import jdtrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output      logic                  req_full,
   input  wire logic                  req_opcode,
   input  wire logic [DATA_W-1:0]     req_command_data,
   input  wire logic [DATA_W-1:0]     req_player_one_port,
   input  wire logic [DATA_W-1:0]     req_player_two_port,
   input  wire logic [OFFSET_W-1:0]   req_reg_offset,
   input  wire logic [DATA_W-1:0]     req_aux_port,
   output      logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   output      logic [DATA_W-1:0]     rsp_read_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type  cfg;
   item_type front_item, back_item;
   logic     front_push, q_full, q_pop, q_empty;

   jdtrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jdtrd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_opcode          (req_opcode),
      .req_command_data    (req_command_data),
      .req_player_one_port (req_player_one_port),
      .req_player_two_port (req_player_two_port),
      .req_reg_offset      (req_reg_offset),
      .req_aux_port        (req_aux_port),
      .q_push              (front_push),
      .q_item              (front_item),
      .q_full              (q_full)
   );

   jdtrd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   jdtrd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_item        (back_item),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_read_data (rsp_read_data)
   );

endmodule

`default_nettype wire

### sv/jdtrd_checker.sv
`default_nettype none

module jdtrd_checker
   import jdtrd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_full,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire logic [DATA_W-1:0]     rsp_read_data,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_prdata,
   input wire logic                  csr_pready
);

   // Reset empties the result buffer.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result channel not empty after reset");

   // Reset frees the request side.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request channel full after reset");

   // The tap gap limit comes out of reset at its default.
   a_reset_cfg: assert property (@(posedge clock)
      reset |=> (csr_paddr != 4'd0 || csr_prdata == 32'd10))
      else $error("tap gap limit has wrong reset value");

   // A waiting result holds until it is popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_read_data)))
      else $error("waiting result changed or vanished");

   // The configuration port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind joystick_double_tap_run_detector_top jdtrd_checker u_checker (.*);

`default_nettype wire

### tb/sv/tb_joystick_double_tap_run_detector_top.sv
`default_nettype none

module tb_joystick_double_tap_run_detector_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jdtrd_pkg::*;

   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_LIMIT   = 4000;
   localparam int PHASE_BEATS  = 130;
   localparam int SAT_POLLS    = 258;

   // One request beat, with an optional byte typed in by hand.
   typedef struct {
      op_type              op;
      logic [DATA_W-1:0]   command;
      logic [DATA_W-1:0]   port_one;
      logic [DATA_W-1:0]   port_two;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   aux;
      bit                  has_typed;
      logic [DATA_W-1:0]   typed_byte;
   } beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic                  req_opcode;
   logic [DATA_W-1:0]     req_command_data;
   logic [DATA_W-1:0]     req_player_one_port;
   logic [DATA_W-1:0]     req_player_two_port;
   logic [OFFSET_W-1:0]   req_reg_offset;
   logic [DATA_W-1:0]     req_aux_port;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [DATA_W-1:0]     rsp_read_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   joystick_double_tap_run_detector_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_opcode          (req_opcode),
      .req_command_data    (req_command_data),
      .req_player_one_port (req_player_one_port),
      .req_player_two_port (req_player_two_port),
      .req_reg_offset      (req_reg_offset),
      .req_aux_port        (req_aux_port),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_read_data       (rsp_read_data),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // Predictor state: one slot per player and direction (player*2 + dir).
   logic              dir_was_held   [4];
   count_type         released_polls [4];
   count_type         pressed_polls  [4];
   logic [1:0]        run_bits       [2];
   logic              button_lock    [2];
   logic [DATA_W-1:0] snapshot       [4];
   logic [DATA_W-1:0] stored_command;
   logic [DATA_W-1:0] tap_gap_cfg;
   logic [DATA_W-1:0] press_len_cfg;
   logic [DATA_W-1:0] lockout_cfg;

   // Read bytes still owed by the block, oldest first.
   logic [DATA_W-1:0] read_results [$];
   logic [DATA_W-1:0] owed_byte;

   // Joystick scripts for the random part.
   logic [DATA_W-1:0] joy_port [2];
   logic [1:0]        joy_dir  [2];
   int                joy_hold [2];

   int  mismatches    = 0;
   int  beats_sent    = 0;
   int  reads_checked = 0;
   int  settings_done = 0;
   int  idle_cycles   = 0;
   int  burst_left    = 0;
   bit  sender_gaps   = 1'b1;
   int  stall_left    = 0;
   int  stall_mode    = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t ns: MISMATCH %s: got %02h, expected %02h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic count_type bump_count(input count_type value);
      return (value == COUNT_MAX) ? value : value + 1'b1;
   endfunction

   // One poll of both joysticks: direction counters, run flags, button
   // latches and the four snapshots.
   function automatic void poll_joysticks(input logic [DATA_W-1:0] port_a,
                                          input logic [DATA_W-1:0] port_b);
      logic [DATA_W-1:0] ports  [2];
      logic [DATA_W-1:0] passed [2];
      logic [DATA_W-1:0] cur_buttons;
      logic              held;
      logic              opposite;
      int                k;
      ports[0] = port_a;
      ports[1] = port_b;
      for (int p = 0; p < 2; p++) begin
         for (int d = 0; d < 2; d++) begin
            k        = p * 2 + d;
            held     = ports[p][d];
            opposite = ports[p][d ^ 1];
            if (!held) begin
               if (dir_was_held[k]) released_polls[k] = '0;
               // The opposite direction locks the release count out.
               if (opposite) begin
                  released_polls[k] = (int'(lockout_cfg) > int'(COUNT_MAX)) ?
                                      COUNT_MAX : count_type'(lockout_cfg);
               end
               released_polls[k] = bump_count(released_polls[k]);
               run_bits[p][d] = 1'b0;
            end else begin
               if (!dir_was_held[k]) begin
                  if (released_polls[k] < tap_gap_cfg && pressed_polls[k] < press_len_cfg)
                     run_bits[p][d] = 1'b1;
                  pressed_polls[k] = '0;
               end
               pressed_polls[k] = bump_count(pressed_polls[k]);
            end
         end
         dir_was_held[p * 2]     = ports[p][0];
         dir_was_held[p * 2 + 1] = ports[p][1];
      end
      // Both buttons pass once, then stay masked until fully released.
      for (int p = 0; p < 2; p++) begin
         cur_buttons = ports[p] & BUTTON_MASK;
         passed[p]   = button_lock[p] ? '0 : cur_buttons;
         if (passed[p] == BUTTON_MASK) button_lock[p] = 1'b1;
         if (cur_buttons == '0) button_lock[p] = 1'b0;
      end
      snapshot[0] = ports[0] & P1_MASK;
      snapshot[1] = ports[1] & P2_MASK;
      snapshot[2] = {{(DATA_W - 2){1'b0}}, run_bits[0]} | passed[0];
      snapshot[3] = {{(DATA_W - 2){1'b0}}, run_bits[1]} | passed[1];
   endfunction

   function automatic logic [DATA_W-1:0] read_byte(input logic [OFFSET_W-1:0] offset,
                                                    input logic [DATA_W-1:0] aux);
      if (stored_command == '0) return SIGNATURE;
      if (offset < SNAP_COUNT) return snapshot[offset[1:0]];
      if (offset == AUX_OFFSET) return aux;
      return snapshot[0];
   endfunction

   function automatic beat_type row(input op_type op, input logic [DATA_W-1:0] command,
                                    input logic [DATA_W-1:0] port_one,
                                    input logic [DATA_W-1:0] port_two,
                                    input logic [OFFSET_W-1:0] offset,
                                    input logic [DATA_W-1:0] aux, input bit has_typed,
                                    input logic [DATA_W-1:0] typed_byte);
      beat_type b;
      b.op         = op;
      b.command    = command;
      b.port_one   = port_one;
      b.port_two   = port_two;
      b.offset     = offset;
      b.aux        = aux;
      b.has_typed  = has_typed;
      b.typed_byte = typed_byte;
      return b;
   endfunction

   // Random beat: joysticks follow short press and release segments so that
   // double taps, lockouts and button latches happen often.
   function automatic beat_type random_beat();
      beat_type   b;
      logic [1:0] dir;
      int         pick;
      for (int p = 0; p < 2; p++) begin
         if (joy_hold[p] == 0) begin
            if ($urandom_range(0, 3) == 0) joy_dir[p] = $urandom_range(0, 1) ? 2'b01 : 2'b10;
            pick = $urandom_range(0, 9);
            if (pick < 4)       dir = 2'b00;
            else if (pick < 8)  dir = joy_dir[p];
            else if (pick == 8) dir = 2'b11;
            else                dir = ~joy_dir[p];
            joy_hold[p] = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) :
                                                         $urandom_range(1, 6);
            joy_port[p] = {2'($urandom), 2'($urandom), 2'($urandom), dir};
         end
         joy_hold[p]--;
      end
      b = row(($urandom_range(0, 99) < 40) ? OP_READ : OP_COMMAND,
              ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom),
              joy_port[0], joy_port[1], OFFSET_W'($urandom), 8'($urandom), 1'b0, 8'h00);
      return b;
   endfunction

   // Drive one beat, wait for the block to take it, then update the predictor.
   task automatic send_beat(input beat_type b);
      req_push            <= 1'b1;
      req_opcode          <= b.op;
      req_command_data    <= b.command;
      req_player_one_port <= b.port_one;
      req_player_two_port <= b.port_two;
      req_reg_offset      <= b.offset;
      req_aux_port        <= b.aux;
      @(posedge clock);
      while (req_full) @(posedge clock);
      beats_sent++;
      if (b.op == OP_READ) begin
         read_results.push_back(b.has_typed ? b.typed_byte : read_byte(b.offset, b.aux));
      end else begin
         stored_command = b.command;
         poll_joysticks(b.port_one, b.port_two);
      end
   endtask

   // Bursts of random length, with random gaps between them while sender_gaps is set.
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (sender_gaps) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Hold off until every read has come back and queued commands have drained.
   task automatic settle();
      req_push <= 1'b0;
      while (read_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register access; a read compares the value against the one given.
   task automatic csr_access(input logic write_en, input logic [1:0] idx,
                             input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (!write_en) begin
         if (csr_prdata[DATA_W-1:0] !== value)
            report_mismatch("register read-back", csr_prdata[DATA_W-1:0], value);
      end else begin
         case (idx)
            REG_TAP_GAP:   tap_gap_cfg   = value;
            REG_PRESS_LEN: press_len_cfg = value;
            REG_LOCKOUT:   lockout_cfg   = value;
            default: ;
         endcase
      end
      // The port goes idle before the next access.
      @(posedge clock);
   endtask

   // Result checker: every popped beat against the oldest owed byte.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         reads_checked++;
         if (read_results.size() == 0) begin
            report_mismatch("read beat with nothing owed", rsp_read_data, 8'h00);
         end else begin
            owed_byte = read_results.pop_front();
            if (rsp_read_data !== owed_byte) report_mismatch("read_data", rsp_read_data, owed_byte);
         end
      end
   end

   // Receiver: steady pops, long stalls and random pops in segments.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(1, 30);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= 1'b0;
         default: rsp_pop <= 1'($urandom_range(0, 1));
      endcase
   end

   // Watchdog on cycles in which no beat moves on any port.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timed out after %0d cycles without progress.", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      beat_type          directed_rows [$];
      beat_type          b;
      logic [DATA_W-1:0] gap_value;
      logic [DATA_W-1:0] press_value;
      logic [DATA_W-1:0] lock_value;

      reset               = 1'b1;
      req_push            = 1'b0;
      req_opcode          = OP_COMMAND;
      req_command_data    = '0;
      req_player_one_port = '0;
      req_player_two_port = '0;
      req_reg_offset      = '0;
      req_aux_port        = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;

      // Predictor reset.
      for (int i = 0; i < 4; i++) begin
         dir_was_held[i]   = 1'b0;
         released_polls[i] = '0;
         pressed_polls[i]  = '0;
         snapshot[i]       = '0;
      end
      for (int i = 0; i < 2; i++) begin
         run_bits[i]    = '0;
         button_lock[i] = 1'b0;
         joy_port[i]    = '0;
         joy_dir[i]     = 2'b01;
         joy_hold[i]    = 0;
      end
      stored_command = '0;
      tap_gap_cfg    = TAP_GAP_RESET;
      press_len_cfg  = PRESS_LEN_RESET;
      lockout_cfg    = LOCKOUT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset limits.
      directed_rows = '{
         // Zero command after reset: signature, even on the auxiliary offset.
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 1'b1, SIGNATURE),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd4, 8'hff, 1'b1, SIGNATURE),
         // Everything pressed from rest: both runs and both buttons.
         row(OP_COMMAND, 8'hff, 8'hff, 8'hff, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 1'b1, 8'hcf),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd1, 8'h00, 1'b1, 8'h0f),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd2, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd3, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd4, 8'h00, 1'b1, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd4, 8'hff, 1'b1, 8'hff),
         // Offsets five to seven read snapshot zero.
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd5, 8'h00, 1'b1, 8'hcf),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd6, 8'h00, 1'b1, 8'hcf),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd7, 8'hff, 1'b1, 8'hcf),
         // Buttons still held: masked now.
         row(OP_COMMAND, 8'h01, 8'hff, 8'hff, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd2, 8'h00, 1'b0, 8'h00),
         // Release all, then a quick second tap.
         row(OP_COMMAND, 8'h80, 8'h00, 8'h00, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd3, 8'h00, 1'b0, 8'h00),
         row(OP_COMMAND, 8'h01, 8'h01, 8'h02, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd2, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd3, 8'h00, 1'b0, 8'h00),
         // Opposite direction held forces the lockout count.
         row(OP_COMMAND, 8'h01, 8'h02, 8'h01, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_COMMAND, 8'h01, 8'h01, 8'h02, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd2, 8'h00, 1'b0, 8'h00),
         // Command back to zero.
         row(OP_COMMAND, 8'h00, 8'h55, 8'haa, 3'd0, 8'h00, 1'b0, 8'h00),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd1, 8'h00, 1'b1, SIGNATURE),
         row(OP_READ,    8'h00, 8'h00, 8'h00, 3'd4, 8'ha5, 1'b1, SIGNATURE)
      };
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i]);
         pace_sender();
      end

      // Random phases, each under a new set of limits written while idle.
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: begin
               gap_value = 8'hff; press_value = 8'hff; lock_value = 8'h00;
            end
            1: begin
               gap_value = 8'h00; press_value = 8'h00; lock_value = 8'hff;
            end
            2: begin
               gap_value = TAP_GAP_RESET; press_value = PRESS_LEN_RESET;
               lock_value = LOCKOUT_RESET;
            end
            default: begin
               gap_value   = 8'($urandom_range(1, 16));
               press_value = 8'($urandom_range(1, 10));
               lock_value  = 8'($urandom);
            end
         endcase
         csr_access(1'b1, REG_TAP_GAP, gap_value);
         csr_access(1'b1, REG_PRESS_LEN, press_value);
         csr_access(1'b1, REG_LOCKOUT, lock_value);
         csr_access(1'b0, REG_TAP_GAP, gap_value);
         csr_access(1'b0, REG_PRESS_LEN, press_value);
         csr_access(1'b0, REG_LOCKOUT, lock_value);
         settings_done++;
         sender_gaps = (phase != 2);

         // With both limits at the top, a long release on player one and a
         // long press on player two must saturate, so no run may follow.
         if (phase == 0) begin
            for (int n = 0; n < SAT_POLLS; n++) begin
               send_beat(row(OP_COMMAND, 8'h01 | 8'($urandom),
                             {2'($urandom), 2'($urandom), 2'($urandom), 2'b00},
                             {2'($urandom), 2'($urandom), 2'($urandom), 2'b01},
                             3'd0, 8'h00, 1'b0, 8'h00));
               pace_sender();
            end
            send_beat(row(OP_COMMAND, 8'h01, 8'h01, 8'h00, 3'd0, 8'h00, 1'b0, 8'h00));
            send_beat(row(OP_COMMAND, 8'h01, 8'h01, 8'h01, 3'd0, 8'h00, 1'b0, 8'h00));
            send_beat(row(OP_READ, 8'h00, 8'h00, 8'h00, 3'd2, 8'h00, 1'b0, 8'h00));
            send_beat(row(OP_READ, 8'h00, 8'h00, 8'h00, 3'd3, 8'h00, 1'b0, 8'h00));
         end

         for (int n = 0; n < PHASE_BEATS; n++) begin
            b = random_beat();
            send_beat(b);
            pace_sender();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request beats and checked %0d read beats under %0d limit settings,",
               beats_sent, reads_checked, settings_done + 1);
      $display("including both limit extremes, lockouts, button latching and saturation.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
